// ===== rtl/pgcb_pkg.sv =====
package pgcb_pkg;

  // fixed point format of the contrast gain
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 9;
  localparam int PROD_W         = GAIN_W + 10;
  localparam int DIV_CNT_W      = $clog2(GAIN_W);

  localparam int PIX_W          = 8;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;

  // contrast pivot
  localparam int CONTRAST_MID   = 127;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_GRAY       = 2'd0,
    REG_CONTRAST   = 2'd1,
    REG_BRIGHTNESS = 2'd2
  } reg_idx_t;

endpackage

// ===== rtl/pixel_gray_contrast_brightness.sv =====
// an accepted input word passes ch1_r, prod_r, ch3_r and out_r to reach out_tdata
// one pixel per clock in a four stage pipeline, unless output or divider stalls it
// a contrast write with a positive value runs a bit-serial gain divider,
// one quotient bit a cycle, and in_tready stays low meanwhile
// reset (rst_n low, synchronous): registers go to zero, gain to unity, pipeline empty
module pixel_gray_contrast_brightness (
  input  logic        clk,
  input  logic        rst_n,
  // input pixel stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  // result pixel stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red_out [7:0], green_out [15:8], blue_out [23:16]
  // register port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pgcb_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [pgcb_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [pgcb_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  localparam int GW = pgcb_pkg::GAIN_W;
  localparam int F  = pgcb_pkg::GAIN_FRAC_BITS;
  localparam int PW = pgcb_pkg::PROD_W;
  localparam int CW = pgcb_pkg::DIV_CNT_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic          gray_r;
  logic [8:0]    contrast_r;
  logic [8:0]    bright_r;
  logic [GW-1:0] gain_r;

  // serial divider for gain = 2^(F+8) / (257 - c)
  logic          div_busy_r;
  logic [GW-1:0] div_num_r;   // dividend shifting out, quotient shifting in
  logic [8:0]    div_rem_r;
  logic [8:0]    div_den_r;
  logic [CW-1:0] div_cnt_r;

  logic          cfg_wr;
  logic [1:0]    cfg_idx;
  logic [8:0]    wr_c;
  logic          wr_c_pos;
  logic [9:0]    den_full;
  logic [9:0]    neg_base;    // 256 + c for c <= 0
  logic [9:0]    rem_sh;
  logic          rem_ge;
  logic [9:0]    rem_sub;
  logic [GW-1:0] div_num_nxt;
  logic [8:0]    div_rem_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];
  assign wr_c       = cfg_pwdata[8:0];
  assign wr_c_pos   = !wr_c[8] && (wr_c[7:0] != 8'd0);
  assign den_full   = 10'd257 - {2'b00, wr_c[7:0]};
  assign neg_base   = 10'd256 + {wr_c[8], wr_c};

  // one restoring division step
  assign rem_sh      = {div_rem_r, div_num_r[GW-1]};
  assign rem_ge      = rem_sh >= {1'b0, div_den_r};
  assign rem_sub     = rem_sh - {1'b0, div_den_r};
  assign div_rem_nxt = rem_ge ? rem_sub[8:0] : rem_sh[8:0];
  assign div_num_nxt = {div_num_r[GW-2:0], rem_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_r     <= 1'b0;
      contrast_r <= 9'd0;
      bright_r   <= 9'd0;
      gain_r     <= GW'(1) << F;
      div_busy_r <= 1'b0;
    end else begin
      // a new contrast word restarts or cancels a running division
      if (cfg_wr && (cfg_idx == pgcb_pkg::REG_CONTRAST)) begin
        contrast_r <= wr_c;
        div_busy_r <= wr_c_pos;
        if (!wr_c_pos) begin
          // exact gain for zero and negative contrast
          gain_r <= GW'(neg_base[8:0]) << (F - 8);
        end
      end else if (div_busy_r && (div_cnt_r == CW'(GW - 1))) begin
        div_busy_r <= 1'b0;
        gain_r     <= div_num_nxt;
      end
      if (cfg_wr) begin
        unique case (cfg_idx)
          pgcb_pkg::REG_GRAY: begin
            gray_r <= cfg_pwdata[0];
          end
          pgcb_pkg::REG_BRIGHTNESS: begin
            bright_r <= cfg_pwdata[8:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // divider datapath, no reset needed
  always_ff @(posedge clk) begin
    if (cfg_wr && (cfg_idx == pgcb_pkg::REG_CONTRAST) && wr_c_pos) begin
      div_num_r <= GW'(1) << (F + 8);
      div_rem_r <= 9'd0;
      div_den_r <= den_full[8:0];
      div_cnt_r <= '0;
    end else if (div_busy_r) begin
      div_num_r <= div_num_nxt;
      div_rem_r <= div_rem_nxt;
      div_cnt_r <= div_cnt_r + CW'(1);
    end
  end

  // register read back, signed fields sign-extended
  always_comb begin
    unique case (cfg_idx)
      pgcb_pkg::REG_GRAY:       cfg_prdata = {31'd0, gray_r};
      pgcb_pkg::REG_CONTRAST:   cfg_prdata = {{23{contrast_r[8]}}, contrast_r};
      pgcb_pkg::REG_BRIGHTNESS: cfg_prdata = {{23{bright_r[8]}}, bright_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: each stage takes a word when it is empty or the
  // next stage moves, so bubbles close up behind a stalled output
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc;

  assign rdy4      = !out_valid_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1 && !div_busy_r;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_acc;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: gray average, sum / 3 as sum * 683 >> 11 (exact for sum <= 765)
  // ---------------------------------------------------------------------------
  logic [2:0][7:0] ch1_nxt, ch1_r;
  logic [9:0]      sum3;
  logic [19:0]     sum_scaled;

  assign sum3       = {2'b00, in_tdata[7:0]} + {2'b00, in_tdata[15:8]}
                    + {2'b00, in_tdata[23:16]};
  assign sum_scaled = {10'd0, sum3} * 20'd683;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch1_nxt[i] = gray_r ? sum_scaled[18:11] : in_tdata[8*i +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) ch1_r <= ch1_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage 2: gain * (x - 127), unity gain when contrast is zero
  // ---------------------------------------------------------------------------
  logic signed [GW:0]              gain_s;
  logic signed [2:0][8:0]          dlt;
  logic signed [PW-1:0]            prod_s [3];
  logic        [2:0][PW-1:0]       prod_nxt, prod_r;

  assign gain_s = $signed({1'b0, gain_r});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlt[i]      = {1'b0, ch1_r[i]} - 9'd127;
      // both factors sign-extended to the product width
      prod_s[i]   = gain_s * $signed(dlt[i]);
      prod_nxt[i] = prod_s[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) prod_r <= prod_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage 3: add pivot back, floor to integer, clamp to 0..255
  // ---------------------------------------------------------------------------
  logic [2:0][PW-1:0] lvl;
  logic [2:0][7:0]    ch3_nxt, ch3_r;
  logic [PW-1:0]      pivot;

  assign pivot = PW'(pgcb_pkg::CONTRAST_MID) << F;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lvl[i] = prod_r[i] + pivot;
      if (lvl[i][PW-1]) begin
        ch3_nxt[i] = 8'd0;
      end else if (|lvl[i][PW-2:F+8]) begin
        ch3_nxt[i] = 8'd255;
      end else begin
        ch3_nxt[i] = lvl[i][F+7:F];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) ch3_r <= ch3_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage 4: brightness offset with saturation, output register
  // ---------------------------------------------------------------------------
  logic [2:0][9:0] bsum;
  logic [2:0][7:0] out_nxt, out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bsum[i] = {2'b00, ch3_r[i]} + {bright_r[8], bright_r};
      if (bsum[i][9]) begin
        out_nxt[i] = 8'd0;
      end else if (bsum[i][8]) begin
        out_nxt[i] = 8'd255;
      end else begin
        out_nxt[i] = bsum[i][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

// ===== rtl/pgcb_checker.sv =====
module pgcb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [23:0]                     out_tdata,
  input logic                            cfg_psel,
  input logic                            cfg_penable,
  input logic                            cfg_pwrite,
  input logic [pgcb_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input logic [pgcb_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input logic                            cfg_pready
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // positive contrast starts the gain divider, which holds off input
  a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
      && (cfg_paddr[3:2] == pgcb_pkg::REG_CONTRAST)
      && !cfg_pwdata[8] && (cfg_pwdata[7:0] != 8'd0)
    |=> !in_tready)
    else $error("input taken while gain is being derived");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("pready low");

endmodule

bind pixel_gray_contrast_brightness pgcb_checker u_pgcb_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pgcb_pkg::*;

  // one pixel as it travels in tdata: [0] red, [1] green, [2] blue
  typedef logic [2:0][PIX_W-1:0] pixel_t;

  localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR = 4'hC;  // index 3, not decoded
  localparam int IDLE_PCT    = 37;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE      = 8;    // extra wait once no word is owed any more
  localparam string CHAN_NAME [3] = '{"red", "green", "blue"};

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;    // red_in [7:0], green_in [15:8], blue_in [23:16]
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;   // red_out [7:0], green_out [15:8], blue_out [23:16]
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // mirror of the block's settings and derived gain
  logic                    mirror_gray;
  logic signed [8:0]       mirror_contrast;
  logic signed [8:0]       mirror_brightness;
  logic [GAIN_W-1:0]       mirror_gain;

  pixel_t pending_pixels [$];   // adjusted pixels still owed by the block
  int     mismatch_count;
  bit     sender_calm;          // no gaps on the input side
  bit     receiver_calm;        // no stalls on the output side
  bit     hold_request;         // ask the receiver for one long hold-off

  pixel_gray_contrast_brightness u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // unsigned gain with GAIN_FRAC_BITS fraction bits, as the block derives it
  function automatic logic [GAIN_W-1:0] gain_of(logic signed [8:0] c);
    longint ci;
    longint g;
    ci = c;
    if (ci <= 0) begin
      g = (256 + ci) << (GAIN_FRAC_BITS - 8);   // exact for the attenuating side
    end else begin
      g = (longint'(256) << GAIN_FRAC_BITS) / (257 - ci);
    end
    return g[GAIN_W-1:0];
  endfunction

  // gain*(x-mid)+mid, floored, clamped to a byte
  function automatic logic [PIX_W-1:0] stretch(logic [PIX_W-1:0] x);
    longint v;
    v = longint'(mirror_gain) * (longint'(x) - CONTRAST_MID)
        + (longint'(CONTRAST_MID) << GAIN_FRAC_BITS);
    if (v < 0) return '0;
    v = v >>> GAIN_FRAC_BITS;
    if (v > 255) return '1;
    return v[PIX_W-1:0];
  endfunction

  // saturating add of the signed offset
  function automatic logic [PIX_W-1:0] brighten(logic [PIX_W-1:0] x);
    int s;
    s = int'(x) + int'(mirror_brightness);
    if (s < 0) return '0;
    if (s > 255) return '1;
    return s[PIX_W-1:0];
  endfunction

  // gray, then contrast, then brightness, each skipped when off
  function automatic pixel_t adjust_pixel(pixel_t p);
    pixel_t q;
    int avg;
    q = p;
    if (mirror_gray) begin
      avg = (int'(p[0]) + int'(p[1]) + int'(p[2])) / 3;
      for (int i = 0; i < 3; i++) q[i] = avg[PIX_W-1:0];
    end
    if (mirror_contrast != 0) begin
      for (int i = 0; i < 3; i++) q[i] = stretch(q[i]);
    end
    if (mirror_brightness != 0) begin
      for (int i = 0; i < 3; i++) q[i] = brighten(q[i]);
    end
    return q;
  endfunction

  function automatic pixel_t px(int r, int g, int b);
    pixel_t p;
    p[0] = r[PIX_W-1:0];
    p[1] = g[PIX_W-1:0];
    p[2] = b[PIX_W-1:0];
    return p;
  endfunction

  // mostly uniform channels, sometimes values around the pivot and the rails
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int corner [7] = '{0, 1, 126, 127, 128, 254, 255};
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(99) < 30) p[i] = corner[$urandom_range(6)][PIX_W-1:0];
      else p[i] = PIX_W'($urandom_range(255));
    end
    return p;
  endfunction

  // signed 9-bit level, biased toward the ends of the range and zero
  function automatic int rand_level();
    case ($urandom_range(7))
      0: return 0;
      1: return -256;
      2: return 255;
      3: return -255;
      4: return 1;
      default: return int'($urandom_range(511)) - 256;
    endcase
  endfunction

  function automatic logic [CFG_ADDR_W-1:0] reg_addr(reg_idx_t r);
    return {r, 2'b00};
  endfunction

  // ---------------------------------------------------------------------------
  // drivers, all called and returning at a falling edge
  // ---------------------------------------------------------------------------

  // offer one word, wait for the handshake, log what the block owes for it
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = 0;
    if (!sender_calm) begin
      while ($urandom_range(99) < IDLE_PCT && gap < 8) gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_pixels.push_back(adjust_pixel(p));
    @(negedge clk);
  endtask

  // stop offering and let every owed word come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // register writes only once the pipeline is empty
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (reg_idx_t'(addr[3:2]))
      REG_GRAY: mirror_gray = data[0];
      REG_CONTRAST: begin
        mirror_contrast = data[8:0];
        mirror_gain     = gain_of(mirror_contrast);
      end
      REG_BRIGHTNESS: mirror_brightness = data[8:0];
      default: ;   // undecoded index, nothing changes
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, or one long counted hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_tready <= receiver_calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted output word against the oldest owed pixel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_pixels.size() == 0) begin
        $display("%0t: output word %h with none outstanding", $time, got);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: %s expected %0d actual %0d", $time, CHAN_NAME[i],
                     want[i], got[i]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all stages off after reset, words pass through unchanged
  task automatic test_bypass();
    send_pixel(px(0, 0, 0));
    send_pixel(px(255, 255, 255));
    send_pixel(px(8'h55, 8'hAA, 8'h80));
    send_pixel(px(8'hAA, 8'h55, 8'h7F));
  endtask

  // averaging floors, upper bits of the written value are dropped
  task automatic test_gray();
    cfg_write(reg_addr(REG_GRAY), 32'hFFFF_FFFF);
    send_pixel(px(255, 255, 254));
    send_pixel(px(0, 0, 2));
    send_pixel(px(255, 255, 255));
    cfg_write(reg_addr(REG_GRAY), 32'hFFFF_FFFE);
  endtask

  // zero gain at the most negative pattern, full divider range at the top
  task automatic test_contrast_extremes();
    cfg_write(reg_addr(REG_CONTRAST), 32'h0000_0100);   // -256, gain of zero
    send_pixel(px(0, 255, 127));
    send_pixel(px(3, 200, 90));
    cfg_write(reg_addr(REG_CONTRAST), 32'd255);         // divisor of 2
    send_pixel(px(126, 127, 128));
    send_pixel(px(0, 255, 130));
    cfg_write(reg_addr(REG_CONTRAST), 32'hFFFF_FF01);   // -255
    send_pixel(px(0, 255, 128));
    cfg_write(reg_addr(REG_CONTRAST), 32'hABCD_E001);   // junk above bit 8, +1
    send_pixel(px(0, 255, 100));
    cfg_write(reg_addr(REG_CONTRAST), 32'd0);
  endtask

  // offset saturation at both rails
  task automatic test_brightness_extremes();
    cfg_write(reg_addr(REG_BRIGHTNESS), 32'h0000_0100); // -256
    send_pixel(px(255, 255, 255));
    cfg_write(reg_addr(REG_BRIGHTNESS), 32'd255);
    send_pixel(px(0, 1, 255));
    cfg_write(reg_addr(REG_BRIGHTNESS), 32'hFFFF_FFFF); // -1
    send_pixel(px(0, 128, 255));
  endtask

  // undecoded index is ignored, then all three stages chained
  task automatic test_register_decode();
    cfg_write(UNUSED_ADDR, 32'hFFFF_FFFF);
    send_pixel(px(10, 20, 30));
    cfg_write(reg_addr(REG_GRAY), 32'd1);
    cfg_write(reg_addr(REG_CONTRAST), 32'd100);
    cfg_write(reg_addr(REG_BRIGHTNESS), 32'hFFFF_FFCE); // -50
    send_pixel(px(200, 40, 90));
    send_pixel(px(255, 0, 130));
  endtask

  // receiver holds off while the sender keeps pushing, input must stall
  task automatic test_backpressure();
    hold_request = 1'b1;
    sender_calm  = 1'b1;
    repeat (30) send_pixel(rand_pixel());
    sender_calm  = 1'b0;
  endtask

  // random settings per phase, random pixels in between
  task automatic test_random();
    int lvl;
    logic [CFG_DATA_W-1:0] junk;
    for (int phase = 0; phase < 12; phase++) begin
      // quiet phase: no gaps and no stalls on either side
      sender_calm   = (phase == 5);
      receiver_calm = (phase == 5);
      cfg_write(reg_addr(REG_GRAY), $urandom());
      for (int r = 0; r < 2; r++) begin
        if ($urandom_range(3) != 0 || phase == 0) begin
          lvl  = rand_level();
          junk = ($urandom_range(3) == 0) ? $urandom() : {CFG_DATA_W{lvl[8]}};
          junk[8:0] = lvl[8:0];
          cfg_write(reg_addr(reg_idx_t'((r == 0) ? REG_CONTRAST : REG_BRIGHTNESS)),
                    junk);
        end
      end
      repeat (34) send_pixel(rand_pixel());
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    hold_request  = 1'b0;
    mismatch_count = 0;

    // settings after reset: all stages off, unity gain
    mirror_gray       = 1'b0;
    mirror_contrast   = '0;
    mirror_brightness = '0;
    mirror_gain       = gain_of(9'sd0);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_bypass();
    test_gray();
    test_contrast_extremes();
    test_brightness_extremes();
    test_register_decode();
    test_backpressure();
    test_random();

    drain();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pgcb_pkg.sv
rtl/pixel_gray_contrast_brightness.sv
rtl/pgcb_checker.sv
dv/tb_top.sv
